// ===== rtl/alc_pkg.sv =====
// shared constants, widths, coefficients and scale table for the lux conversion
// no dependencies; imported by alc_horner, ambient_light_lux_conversion_top, lux_checker and testbench
package alc_pkg;

  // sizing of the count and of the output fraction
  localparam int COUNT_BITS    = 16;
  localparam int OUT_FRAC_BITS = 8;

  // port widths
  localparam int RAW_COUNTS_W = 16;
  localparam int LUX_OUT_W    = 36;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 8;
  localparam int GAIN_W       = 2;
  localparam int INTEG_W      = 3;

  // count bits actually used from the port
  localparam int RAW_W  = (COUNT_BITS < RAW_COUNTS_W) ? COUNT_BITS : RAW_COUNTS_W;

  // scale factor, unsigned q1.20
  localparam int SCALE_W = 21;
  localparam int PROD_W  = RAW_W + SCALE_W;
  localparam int SHR_W   = PROD_W - 3;

  // scaled lux x, q17.16, saturated at 33 bits
  localparam int X_W = 33;
  localparam longint X_MAX = (64'sd1 <<< X_W) - 64'sd1;

  // horner chain widths
  localparam int C3_W   = 20;
  localparam int M3_W   = C3_W + X_W;
  localparam int R3_W   = M3_W - 15;
  localparam int S60_W  = R3_W + 1;
  localparam int T44_W  = 22;
  localparam int M2_W   = T44_W + X_W + 1;
  localparam int S44_W  = M2_W - 16;
  localparam int U28_W  = 23;
  localparam int M1_W   = U28_W + X_W + 1;
  localparam int P_W    = M1_W - 16;
  localparam int PU_W   = 39;

  // final product, split so each multiply stays narrow
  localparam int SPLIT_BITS = 20;
  localparam int HI_W       = PU_W - SPLIT_BITS;
  localparam int MH_W       = X_W + HI_W;
  localparam int ML_W       = X_W + SPLIT_BITS;
  localparam int ACC_W      = MH_W + 2;
  localparam int RSH        = 44 - OUT_FRAC_BITS - SPLIT_BITS;
  localparam int ACCS_W     = ACC_W - RSH;
  localparam longint OUT_MAX = (64'sd1 <<< LUX_OUT_W) - 64'sd1;

  // rounding constants
  localparam longint HALF16   = 64'sd32768;
  localparam longint HALF_OUT = 64'sd1 <<< (RSH - 1);

  // correction coefficients
  localparam longint COEF3_Q60 = 64'sd693309;
  localparam longint COEF2_Q60 = -64'sd10828699940;
  localparam longint COEF1_Q44 = 64'sd1433552056;
  localparam longint COEF0_Q28 = 64'sd269052858;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN  = 4'd0,
    CFG_INTEG = 4'd1
  } alc_cfg_idx_e;

  // scaled lux handed to the correction pipeline
  typedef struct packed {
    logic           vld;
    logic [X_W-1:0] x;
  } alc_x_t;

  // gain times integration factor, q1.20, rows by gain code
  localparam logic [SCALE_W-1:0] SCALE_TBL [4][6] = '{
    '{21'd241592,  21'd120796, 21'd60398,  21'd30199,  21'd15099,  21'd7550},
    '{21'd120796,  21'd60398,  21'd30199,  21'd15099,  21'd7550,   21'd3775},
    '{21'd1932735, 21'd966368, 21'd483184, 21'd241592, 21'd120796, 21'd60398},
    '{21'd966368,  21'd483184, 21'd241592, 21'd120796, 21'd60398,  21'd30199}
  };

  // unused integration codes act as 25 ms
  function automatic logic [SCALE_W-1:0] scale_q20(logic [GAIN_W-1:0]  g,
                                                   logic [INTEG_W-1:0] t);
    logic [INTEG_W-1:0] ti;
    ti = (t > 3'd5) ? '0 : t;
    return SCALE_TBL[g][ti];
  endfunction

endpackage

// ===== rtl/alc_horner.sv =====
// quartic linearity correction pipeline and final scaling of the lux value
// depends on alc_pkg
module alc_horner import alc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  alc_x_t               x_i,
  output logic                 lux_valid_o,
  output logic [LUX_OUT_W-1:0] lux_out_o
);

  localparam int NSTG = 8;

  logic [NSTG-1:0] vld_q;

  logic [M3_W-1:0]  m3_q, m3_d;
  logic [T44_W-1:0] t44_q, t44_d;
  logic [M2_W-1:0]  m2_q, m2_d;
  logic [U28_W-1:0] u28_q, u28_d;
  logic [M1_W-1:0]  m1_q, m1_d;
  logic [PU_W-1:0]  p_q, p_d;
  logic [MH_W-1:0]  mh_q, mh_d;
  logic [ML_W-1:0]  ml_q, ml_d;
  logic [LUX_OUT_W-1:0] lux_q, lux_d;
  logic [X_W-1:0] x3_q, x4_q, x5_q, x6_q, x7_q, x8_q;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], x_i.vld};
    end
  end

  // c3 * x
  always_comb begin
    m3_d = M3_W'(COEF3_Q60) * M3_W'(x_i.x);
  end

  // t = c2 + round(c3*x), then round to q44
  always_comb begin
    logic [M3_W:0]    sum3;
    logic [R3_W-1:0]  r3;
    logic [S60_W-1:0] s60;
    logic [S60_W:0]   s60r;
    sum3  = (M3_W+1)'(m3_q) + (M3_W+1)'(HALF16);
    r3    = sum3[M3_W:16];
    s60   = S60_W'(r3) + S60_W'(COEF2_Q60);
    s60r  = {s60[S60_W-1], s60} + (S60_W+1)'(HALF16) - (S60_W+1)'(s60[S60_W-1]);
    t44_d = s60r[16 +: T44_W];
  end

  // t * x
  always_comb begin
    logic signed [M2_W-1:0] ma, mb;
    ma   = M2_W'($signed(t44_q));
    mb   = M2_W'({1'b0, x4_q});
    m2_d = ma * mb;
  end

  // u = c1 + round(t*x), then round to q28
  always_comb begin
    logic [M2_W-1:0]  r2;
    logic [S44_W-1:0] s44;
    logic [S44_W:0]   s44r;
    r2    = m2_q + M2_W'(HALF16) - M2_W'(m2_q[M2_W-1]);
    s44   = r2[M2_W-1:16] + S44_W'(COEF1_Q44);
    s44r  = {s44[S44_W-1], s44} + (S44_W+1)'(HALF16) - (S44_W+1)'(s44[S44_W-1]);
    u28_d = s44r[16 +: U28_W];
  end

  // u * x
  always_comb begin
    logic signed [M1_W-1:0] ma, mb;
    ma   = M1_W'($signed(u28_q));
    mb   = M1_W'({1'b0, x6_q});
    m1_d = ma * mb;
  end

  // p = c0 + round(u*x), clamped at zero
  always_comb begin
    logic [M1_W-1:0] r1;
    logic [P_W-1:0]  p;
    r1  = m1_q + M1_W'(HALF16) - M1_W'(m1_q[M1_W-1]);
    p   = r1[M1_W-1:16] + P_W'(COEF0_Q28);
    p_d = p[P_W-1] ? '0 : p[PU_W-1:0];
  end

  // x * p as high and low partial products
  always_comb begin
    mh_d = MH_W'(x8_q) * MH_W'(p_q[PU_W-1:SPLIT_BITS]);
    ml_d = ML_W'(x8_q) * ML_W'(p_q[SPLIT_BITS-1:0]);
  end

  // combine, round to the output fraction and saturate
  always_comb begin
    logic [ACC_W-1:0]            acc;
    logic [ACCS_W+LUX_OUT_W-1:0] accw;
    acc   = ACC_W'(mh_q) + ACC_W'(ml_q[ML_W-1:SPLIT_BITS]) + ACC_W'(HALF_OUT);
    accw  = (ACCS_W+LUX_OUT_W)'(acc[ACC_W-1:RSH]);
    lux_d = (accw > (ACCS_W+LUX_OUT_W)'(OUT_MAX)) ? LUX_OUT_W'(OUT_MAX)
                                                  : LUX_OUT_W'(accw);
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    m3_q  <= m3_d;
    x3_q  <= x_i.x;
    t44_q <= t44_d;
    x4_q  <= x3_q;
    m2_q  <= m2_d;
    x5_q  <= x4_q;
    u28_q <= u28_d;
    x6_q  <= x5_q;
    m1_q  <= m1_d;
    x7_q  <= x6_q;
    p_q   <= p_d;
    x8_q  <= x7_q;
    mh_q  <= mh_d;
    ml_q  <= ml_d;
    lux_q <= lux_d;
  end

  assign lux_valid_o = vld_q[NSTG-1];
  assign lux_out_o   = lux_q;

`ifndef SYNTHESIS
  // every item entering comes out at lux_valid_o
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_i.vld |-> ##8 lux_valid_o)
    else $error("item lost in correction pipeline");

  // no result without an item entering earlier
  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lux_valid_o |-> $past(x_i.vld, 8))
    else $error("result without a matching item");

  // zero light gives zero lux
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lux_valid_o && $past(x_i.vld && (x_i.x == '0), 8)) |-> (lux_out_o == '0))
    else $error("nonzero lux for zero scaled count");
`endif

endmodule

// ===== rtl/ambient_light_lux_conversion_top.sv =====
// top level: configuration registers, scale factor lookup and count scaling
// depends on alc_pkg and alc_horner
//
// converts a raw ambient-light count into corrected lux, unsigned with
// OUT_FRAC_BITS fraction bits, saturating at the output width.
// input: an item is taken at a clock edge with start high and busy low;
//   raw_counts_i is sampled at that edge.
// output: lux_valid_o is high for exactly one cycle per item with lux_out_o;
//   the receiver cannot stall, results must be taken as they appear.
// throughput: one item per cycle while busy is low, set by the 11-stage pipeline in which each
//   multiply (count by factor, three horner steps, split final product)
//   has a stage of its own.
// configuration: cfg_valid_i/cfg_ready_o write cfg_data_i into register
//   cfg_index_i (0 gain code, 1 integration code); other indexes are dropped.
//   write only while no item is in flight.
// reset: asynchronous, active low; gain code 2, integration code 0,
//   pipeline emptied; busy is high for the first cycle after release.
module ambient_light_lux_conversion_top import alc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [RAW_COUNTS_W-1:0] raw_counts_i,
  output logic                    lux_valid_o,
  output logic [LUX_OUT_W-1:0]    lux_out_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  logic busy_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [INTEG_W-1:0] integ_q;
  logic take;
  logic v0_q, v1_q, v2_q;
  logic [RAW_W-1:0]   raw0_q;
  logic [SCALE_W-1:0] scale0_q;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [X_W-1:0]     x_q, x_d;
  alc_x_t             xitem;

  // held off for one cycle after reset release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q;
  assign take        = start && !busy_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= 2'd2;
      integ_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GAIN:  gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG: integ_q <= cfg_data_i[INTEG_W-1:0];
        default:   ;
      endcase
    end
  end

  // valid bits of the scaling stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= take;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // count times factor
  always_comb begin
    prod_d = PROD_W'(raw0_q) * PROD_W'(scale0_q);
  end

  // q.20 to q17.16 with round half up, saturated
  always_comb begin
    logic [PROD_W:0]        sum;
    logic [SHR_W+X_W-1:0]   xw;
    sum = (PROD_W+1)'(prod_q) + (PROD_W+1)'(8);
    xw  = (SHR_W+X_W)'(sum[PROD_W:4]);
    x_d = (xw > (SHR_W+X_W)'(X_MAX)) ? X_W'(X_MAX) : X_W'(xw);
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (take) begin
      raw0_q   <= raw_counts_i[RAW_W-1:0];
      scale0_q <= scale_q20(gain_q, integ_q);
    end
    prod_q <= prod_d;
    x_q    <= x_d;
  end

  assign xitem.vld = v2_q;
  assign xitem.x   = x_q;

  alc_horner u_horner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .x_i         (xitem),
    .lux_valid_o (lux_valid_o),
    .lux_out_o   (lux_out_o)
  );

endmodule

// ===== tb/lux_checker.sv =====
// result checker for the lux conversion: predicts each item's lux and compares
// depends on alc_pkg for port widths and register indexes; watches the uut ports
module lux_checker import alc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic [RAW_COUNTS_W-1:0] raw_counts_i,
  input  logic                    lux_valid_o,
  input  logic [LUX_OUT_W-1:0]    lux_out_o,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // gain times integration factor, unsigned q1.20, rows by gain code
  localparam logic [20:0] FACTOR_Q20 [0:3][0:5] = '{
    '{21'd241592,  21'd120796, 21'd60398,  21'd30199,  21'd15099,  21'd7550},
    '{21'd120796,  21'd60398,  21'd30199,  21'd15099,  21'd7550,   21'd3775},
    '{21'd1932735, 21'd966368, 21'd483184, 21'd241592, 21'd120796, 21'd60398},
    '{21'd966368,  21'd483184, 21'd241592, 21'd120796, 21'd60398,  21'd30199}
  };

  // correction polynomial coefficients
  localparam longint C3_Q60 = 64'sd693309;
  localparam longint C2_Q60 = -64'sd10828699940;
  localparam longint C1_Q44 = 64'sd1433552056;
  localparam longint C0_Q28 = 64'sd269052858;

  localparam longint unsigned SCALED_MAX = (64'd1 << 33) - 64'd1;
  localparam longint unsigned LUX_MAX    = (64'd1 << 36) - 64'd1;

  logic [GAIN_W-1:0]    gain_code  = 2'd2;
  logic [INTEG_W-1:0]   integ_code = 3'd0;
  logic [LUX_OUT_W-1:0] lux_expected_q [$];
  logic [LUX_OUT_W-1:0] lux_want;
  int                   fails = 0;

  // signed right shift, rounded to nearest with ties away from zero
  function automatic longint shift_round(longint v, int s);
    longint unsigned mag;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // scale the count, run the horner chain, form the saturated output
  function automatic logic [LUX_OUT_W-1:0] predict_lux(logic [RAW_COUNTS_W-1:0] raw,
                                                       logic [GAIN_W-1:0] g,
                                                       logic [INTEG_W-1:0] t);
    logic [INTEG_W-1:0] ti;
    longint unsigned    x, hi, lo, acc;
    longint             xs, stage, p;
    ti = (t > 3'd5) ? 3'd0 : t;
    x = (64'(raw) * 64'(FACTOR_Q20[g][ti]) + 64'd8) >> 4;
    if (x > SCALED_MAX) x = SCALED_MAX;
    xs = longint'(x);
    stage = C2_Q60 + shift_round(C3_Q60 * xs, 16);
    stage = shift_round(stage, 16);
    stage = C1_Q44 + shift_round(stage * xs, 16);
    stage = shift_round(stage, 16);
    p = C0_Q28 + shift_round(stage * xs, 16);
    if (p < 0) p = 0;
    // x * p from q.44 down to 8 fraction bits, split to keep products narrow
    hi = 64'(p) >> 20;
    lo = 64'(p) & 64'hF_FFFF;
    acc = x * hi + ((x * lo) >> 20);
    acc = (acc + (64'd1 << 15)) >> 16;
    if (acc > LUX_MAX) acc = LUX_MAX;
    return acc[LUX_OUT_W-1:0];
  endfunction

  // track register writes, predict accepted items, check results in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_code  = 2'd2;
      integ_code = 3'd0;
      lux_expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_GAIN) gain_code = cfg_data_i[GAIN_W-1:0];
        else if (cfg_index_i == CFG_INTEG) integ_code = cfg_data_i[INTEG_W-1:0];
      end
      if (lux_valid_o) begin
        if (lux_expected_q.size() == 0) begin
          $error("lux_out: result with no item pending, actual %0d", lux_out_o);
          fails++;
        end else begin
          lux_want = lux_expected_q.pop_front();
          if (lux_out_o !== lux_want) begin
            $error("lux_out mismatch: expected %0d, actual %0d", lux_want, lux_out_o);
            fails++;
          end
        end
      end
      if (start && !busy)
        lux_expected_q.push_back(predict_lux(raw_counts_i, gain_code, integ_code));
      pending_o    <= lux_expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// top of the lux conversion testbench: clock, reset, stimulus and verdict
// depends on alc_pkg, ambient_light_lux_conversion_top and lux_checker
module testbench import alc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 122;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    start        = 1'b0;
  logic                    busy;
  logic [RAW_COUNTS_W-1:0] raw_counts_i = '0;
  logic                    lux_valid_o;
  logic [LUX_OUT_W-1:0]    lux_out_o;
  logic                    cfg_valid_i  = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i   = '0;

  int fail_count;
  int pending;
  int cycle_count    = 0;
  int counts_sent    = 0;
  int settings_used  = 0;

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  ambient_light_lux_conversion_top uut (
    .clk_i, .rst_ni, .start, .busy, .raw_counts_i, .lux_valid_o, .lux_out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  lux_checker lux_check (
    .clk_i, .rst_ni, .start, .busy, .raw_counts_i, .lux_valid_o, .lux_out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // present one count and hold it until the block takes it
  task automatic send_count(input logic [RAW_COUNTS_W-1:0] v);
    start        <= 1'b1;
    raw_counts_i <= v;
    do @(posedge clk_i); while (busy);
    counts_sent++;
  endtask

  // sender gap with junk on the data port
  task automatic pause_input(input int n);
    start        <= 1'b0;
    raw_counts_i <= RAW_COUNTS_W'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  // stop sending and wait until every predicted lux has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] gain_data,
                          input logic [CFG_DATA_W-1:0] integ_data);
    drain_results();
    write_reg(CFG_GAIN, gain_data);
    write_reg(CFG_INTEG, integ_data);
    settings_used++;
  endtask

  // mostly wide random counts, with extremes, small values and single bits
  function automatic logic [RAW_COUNTS_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return 16'd1;
          default: return 16'hFFFE;
        endcase
      end
      1, 2: return RAW_COUNTS_W'($urandom_range(0, 255));
      3: return RAW_COUNTS_W'(1) << $urandom_range(0, RAW_COUNTS_W - 1);
      default: return RAW_COUNTS_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [GAIN_W-1:0]  g;
    logic [INTEG_W-1:0] t;
    bit                 quiet;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    settings_used = 1;

    // reset setting: gain code 2, 25 ms, largest factor
    send_count(16'd0);
    send_count(16'hFFFF);
    send_count(16'd1);
    send_count(16'h5555);
    send_count(16'hAAAA);
    send_count(16'h8000);

    // smallest factor, written with junk in the upper data bits
    set_regs(8'hFD, 8'hFD);
    write_reg(4'd2, 8'h00);
    write_reg(4'hF, 8'hFF);
    send_count(16'hFFFF);
    send_count(16'd1);
    send_count(16'h7FFF);

    // unused integration codes fall back to 25 ms
    set_regs(8'h00, 8'h06);
    send_count(16'hFFFF);
    send_count(16'd12345);
    set_regs(8'h03, 8'hFF);
    send_count(16'hFFFF);
    send_count(16'hFFFE);

    // integration codes 1 to 4 at gain code 2
    for (int i = 1; i <= 4; i++) begin
      set_regs(8'h02, CFG_DATA_W'(i));
      send_count(16'hFFFF);
    end

    // random phases, the first few at fixed corner settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin g = 2'd2; t = 3'd0; end
        1: begin g = 2'd1; t = 3'd5; end
        2: begin g = 2'd0; t = 3'd6; end
        3: begin g = 2'd3; t = 3'd7; end
        4: begin g = 2'd2; t = 3'd5; end
        5: begin g = 2'd0; t = 3'd0; end
        default: begin
          g = GAIN_W'($urandom);
          t = INTEG_W'($urandom);
        end
      endcase
      set_regs({6'($urandom), g}, {5'($urandom), t});
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
      quiet = (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 8 && k == PHASE_ITEMS / 2)
          drain_results();
        else if (!quiet && $urandom_range(0, 99) < 7)
          pause_input($urandom_range(1, 6));
        send_count(pick_count());
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);

    $display("summary: %0d counts over %0d register settings", counts_sent, settings_used);
    $display("summary: all gain and integration codes, stray indexes, wide register data");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
